// ----- rtl/nnl_pkg.sv -----
package nnl_pkg;

    localparam int FREQ_W         = 21;
    localparam int INDEX_W        = 7;
    localparam int DEV_W          = 18;
    localparam int LISTED_NOTES   = 108;
    localparam int NOTE_COUNT_DEF = 108;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int DEV_MAX        = 131071;
    localparam int DEV_MIN        = -131072;
    localparam int MILLI          = 1000;
    localparam int HALF_MILLI     = 500;

    // Integer part of a table entry needs 13 bits, so entries are 13 + FRAC_BITS wide.
    localparam int NOTE_INT_W     = 13;

    // Note frequencies in thousandths of a hertz, C0 up to B8.
    localparam logic [22:0] NOTE_MILLI_HZ [LISTED_NOTES] = '{
        23'd16352,   23'd17324,   23'd18354,   23'd20000,   23'd21000,   23'd22000,
        23'd23000,   23'd25000,   23'd26000,   23'd28000,   23'd29000,   23'd31000,
        23'd33000,   23'd35000,   23'd37000,   23'd39000,   23'd41000,   23'd44000,
        23'd46000,   23'd49000,   23'd52000,   23'd55000,   23'd58000,   23'd62000,
        23'd65000,   23'd69000,   23'd73000,   23'd78000,   23'd82000,   23'd87000,
        23'd93000,   23'd98000,   23'd104000,  23'd110000,  23'd117000,  23'd124000,
        23'd131000,  23'd139000,  23'd147000,  23'd156000,  23'd165000,  23'd175000,
        23'd185000,  23'd196000,  23'd208000,  23'd220000,  23'd233000,  23'd247000,
        23'd262000,  23'd278000,  23'd294000,  23'd311000,  23'd330000,  23'd349000,
        23'd370000,  23'd392000,  23'd415000,  23'd440000,  23'd466000,  23'd494000,
        23'd523000,  23'd554000,  23'd587000,  23'd622000,  23'd659000,  23'd699000,
        23'd740000,  23'd784000,  23'd831000,  23'd880000,  23'd932000,  23'd988000,
        23'd1047000, 23'd1109000, 23'd1175000, 23'd1245000, 23'd1319000, 23'd1397000,
        23'd1475000, 23'd1568000, 23'd1661000, 23'd1760000, 23'd1865000, 23'd1976000,
        23'd2093000, 23'd2218000, 23'd2349000, 23'd2489000, 23'd2637000, 23'd2794000,
        23'd2960000, 23'd3136000, 23'd3322000, 23'd3520000, 23'd3729000, 23'd3951000,
        23'd4186000, 23'd4435000, 23'd4699000, 23'd4978000, 23'd5274000, 23'd5588000,
        23'd5920000, 23'd6272000, 23'd6645000, 23'd7040000, 23'd7459000, 23'd7902000
    };

    // Table entry in fixed point, rounded half up. Used at elaboration only.
    function automatic longint note_fixed(input int idx, input int frac);
        longint m;
        if (idx >= LISTED_NOTES) begin
            return 0;
        end
        m = longint'(NOTE_MILLI_HZ[idx]) << frac;
        return (m + HALF_MILLI) / MILLI;
    endfunction

endpackage

// ----- rtl/nearest_note_lookup.sv -----
// Nearest note lookup.
// Input channel: i_in_valid / o_in_ready carry one frequency, i_freq_in, unsigned with
// FRAC_BITS fraction bits. Output channel: o_out_valid / i_out_ready carry o_in_range,
// o_note_index and the signed deviation o_deviation (input minus chosen note, saturated).
// One transaction is handled at a time; o_in_ready is high only while the sequencer is idle.
// All compares and differences go through one shared subtractor against a constant note
// ROM, one ROM probe per cycle. An in-range item takes two range probes, one probe per
// binary search step (6 or 7 for 108 notes), a final probe of the upper bracket entry, two
// neighbour probes, a decision state and the load of the output register. An out-of-range
// item leaves after the failing range probe and goes straight to the output load. The result
// sits in an output register, so a new transaction is taken while it waits; when the
// receiver stalls, a finished result waits in the sequencer until the output register frees
// and no further item is accepted meanwhile.
// Reset is synchronous and active low and returns the sequencer to idle with the output
// register empty; there is no other state to clear.
module nearest_note_lookup
    import nnl_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FREQ_W-1:0]       i_freq_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_in_range,
    output logic [INDEX_W-1:0]      o_note_index,
    output logic signed [DEV_W-1:0] o_deviation
);

    localparam int IDX_W = $clog2(NOTE_COUNT);
    localparam int EW    = NOTE_INT_W + FRAC_BITS;
    localparam int DW    = ((EW > FREQ_W) ? EW : FREQ_W) + 1;

    localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(NOTE_COUNT - 1);
    localparam logic signed [DW-1:0]   SAT_MAX  = DW'(DEV_MAX);
    localparam logic signed [DW-1:0]   SAT_MIN  = DW'(DEV_MIN);
    localparam logic signed [DEV_W-1:0] OOR_DEV = DEV_W'(-(1 <<< FRAC_BITS));

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE_LO,
        S_RANGE_HI,
        S_SEARCH,
        S_NEIGH_UP,
        S_NEIGH_DN,
        S_DECIDE,
        S_EMIT
    } t_state;

    // Constant note table.
    logic [EW-1:0] rom [NOTE_COUNT];

    for (genvar g = 0; g < NOTE_COUNT; g++) begin : g_rom
        localparam logic [EW-1:0] ENTRY = EW'(note_fixed(g, FRAC_BITS));
        assign rom[g] = ENTRY;
    end

    t_state                   r_state, n_state;
    logic [FREQ_W-1:0]        r_f, n_f;
    logic [IDX_W-1:0]         r_lo, n_lo;
    logic [IDX_W-1:0]         r_hi, n_hi;
    logic signed [DW-1:0]     r_a, n_a;
    logic signed [DW-1:0]     r_b, n_b;
    logic signed [DW-1:0]     r_c, n_c;
    logic                     r_res_in_range, n_res_in_range;
    logic [INDEX_W-1:0]       r_res_index, n_res_index;
    logic signed [DEV_W-1:0]  r_res_dev, n_res_dev;
    logic                     r_out_valid, n_out_valid;
    logic                     r_in_range, n_in_range;
    logic [INDEX_W-1:0]       r_note_index, n_note_index;
    logic signed [DEV_W-1:0]  r_deviation, n_deviation;

    logic [IDX_W-1:0]         span;
    logic                     wide;
    logic [IDX_W-1:0]         mid;
    logic [IDX_W-1:0]         sel;
    logic signed [DW-1:0]     diff;
    logic                     has_up;
    logic                     has_down;
    logic [DW-1:0]            abs_a;
    logic [DW-1:0]            abs_b;
    logic [DW-1:0]            abs_c;
    logic [IDX_W-1:0]         pick;
    logic signed [DW-1:0]     pick_dev;
    logic signed [DEV_W-1:0]  sat_dev;
    logic                     out_free;

    assign span     = r_hi - r_lo;
    assign wide     = span > IDX_W'(1);
    assign mid      = r_lo + (span >> 1);
    assign has_up   = r_hi != LAST_IDX;
    assign has_down = r_hi != '0;
    assign out_free = !r_out_valid || i_out_ready;

    // Address of the one ROM probe of this cycle.
    always_comb begin
        unique case (r_state)
            S_RANGE_LO: sel = '0;
            S_RANGE_HI: sel = LAST_IDX;
            S_SEARCH:   sel = wide ? mid : r_hi;
            S_NEIGH_UP: sel = has_up ? r_hi + IDX_W'(1) : r_hi;
            S_NEIGH_DN: sel = r_hi - IDX_W'(1);
            default:    sel = r_hi;
        endcase
    end

    // The shared subtractor: input minus the probed entry.
    assign diff = $signed(DW'(r_f) - DW'(rom[sel]));

    assign abs_a = r_a[DW-1] ? DW'(-r_a) : DW'(r_a);
    assign abs_b = r_b[DW-1] ? DW'(-r_b) : DW'(r_b);
    assign abs_c = r_c[DW-1] ? DW'(-r_c) : DW'(r_c);

    // A neighbour past either end of the table never wins; ties keep the search result.
    always_comb begin
        priority if (has_up && abs_a > abs_b) begin
            if (has_down && r_b > r_c) begin
                pick     = r_hi - IDX_W'(1);
                pick_dev = r_c;
            end else begin
                pick     = r_hi + IDX_W'(1);
                pick_dev = r_b;
            end
        end else if (has_down && abs_a > abs_c) begin
            pick     = r_hi - IDX_W'(1);
            pick_dev = r_c;
        end else begin
            pick     = r_hi;
            pick_dev = r_a;
        end
    end

    always_comb begin
        priority if (pick_dev > SAT_MAX) begin
            sat_dev = DEV_W'(SAT_MAX);
        end else if (pick_dev < SAT_MIN) begin
            sat_dev = DEV_W'(SAT_MIN);
        end else begin
            sat_dev = DEV_W'(pick_dev);
        end
    end

    always_comb begin
        n_state        = r_state;
        n_f            = r_f;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_a            = r_a;
        n_b            = r_b;
        n_c            = r_c;
        n_res_in_range = r_res_in_range;
        n_res_index    = r_res_index;
        n_res_dev      = r_res_dev;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_in_range     = r_in_range;
        n_note_index   = r_note_index;
        n_deviation    = r_deviation;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_f     = i_freq_in;
                    n_lo    = '0;
                    n_hi    = LAST_IDX;
                    n_state = S_RANGE_LO;
                end
            end
            S_RANGE_LO: begin
                if (diff < 0) begin
                    n_res_in_range = 1'b0;
                    n_res_index    = '0;
                    n_res_dev      = OOR_DEV;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_RANGE_HI;
                end
            end
            S_RANGE_HI: begin
                if (diff > 0) begin
                    n_res_in_range = 1'b0;
                    n_res_index    = '0;
                    n_res_dev      = OOR_DEV;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (wide) begin
                    if (diff < 0) begin
                        n_hi = mid;
                    end else begin
                        n_lo = mid;
                    end
                end else begin
                    // Bracket is one wide: the probe was the upper entry itself.
                    n_a     = diff;
                    n_state = S_NEIGH_UP;
                end
            end
            S_NEIGH_UP: begin
                n_b     = diff;
                n_state = S_NEIGH_DN;
            end
            S_NEIGH_DN: begin
                n_c     = diff;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_res_in_range = 1'b1;
                n_res_index    = INDEX_W'(pick);
                n_res_dev      = sat_dev;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_in_range   = r_res_in_range;
                    n_note_index = r_res_index;
                    n_deviation  = r_res_dev;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_f            <= n_f;
        r_lo           <= n_lo;
        r_hi           <= n_hi;
        r_a            <= n_a;
        r_b            <= n_b;
        r_c            <= n_c;
        r_res_in_range <= n_res_in_range;
        r_res_index    <= n_res_index;
        r_res_dev      <= n_res_dev;
        r_in_range     <= n_in_range;
        r_note_index   <= n_note_index;
        r_deviation    <= n_deviation;
    end

    assign o_in_ready   = r_state == S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_in_range   = r_in_range;
    assign o_note_index = r_note_index;
    assign o_deviation  = r_deviation;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a transaction is in progress");

    a_bracket_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo < r_hi))
        else $error("search bracket collapsed");

    a_out_of_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_range) |-> (o_note_index == '0 && o_deviation == OOR_DEV))
        else $error("out-of-range result has wrong index or deviation");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_out_ready) |=> (r_state == S_EMIT))
        else $error("result left the sequencer while the output was stalled");

endmodule

// ----- tb/note_checker.sv -----
`timescale 1ns / 100ps

module note_checker
    import nnl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [FREQ_W-1:0]       i_freq_in,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_in_range,
    input  logic [INDEX_W-1:0]      i_note_index,
    input  logic signed [DEV_W-1:0] i_deviation,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int TABLE_SIZE   = 108;
    localparam int NOTES        = NOTE_COUNT_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int REPORT_LIMIT = 10;

    // Note frequencies in millihertz, C0 up to B8.
    localparam int NOTE_MHZ [TABLE_SIZE] = '{
        16352, 17324, 18354, 20000, 21000, 22000, 23000, 25000, 26000, 28000, 29000, 31000,
        33000, 35000, 37000, 39000, 41000, 44000, 46000, 49000, 52000, 55000, 58000, 62000,
        65000, 69000, 73000, 78000, 82000, 87000, 93000, 98000, 104000, 110000, 117000,
        124000, 131000, 139000, 147000, 156000, 165000, 175000, 185000, 196000, 208000,
        220000, 233000, 247000, 262000, 278000, 294000, 311000, 330000, 349000, 370000,
        392000, 415000, 440000, 466000, 494000, 523000, 554000, 587000, 622000, 659000,
        699000, 740000, 784000, 831000, 880000, 932000, 988000, 1047000, 1109000, 1175000,
        1245000, 1319000, 1397000, 1475000, 1568000, 1661000, 1760000, 1865000, 1976000,
        2093000, 2218000, 2349000, 2489000, 2637000, 2794000, 2960000, 3136000, 3322000,
        3520000, 3729000, 3951000, 4186000, 4435000, 4699000, 4978000, 5274000, 5588000,
        5920000, 6272000, 6645000, 7040000, 7459000, 7902000
    };

    typedef struct packed {
        logic                    in_range;
        logic [INDEX_W-1:0]      index;
        logic signed [DEV_W-1:0] dev;
    } t_note_match;

    typedef struct {
        logic [FREQ_W-1:0] freq;
        t_note_match       match;
    } t_lookup;

    t_lookup lookup_q[$];
    int      mismatches = 0;
    int      pending_q  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_q;

    function automatic longint pitch_fixed(input int i);
        if (i >= TABLE_SIZE) begin
            return 0;
        end
        return ((longint'(NOTE_MHZ[i]) << FRAC) + 500) / 1000;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_note_match nearest_note(input logic [FREQ_W-1:0] f);
        t_note_match r;
        longint      fv, a, b, c, dev;
        int          lo, hi, mid, idx, pick;
        bit          has_up, has_down;
        fv = longint'(f);
        if (fv > pitch_fixed(NOTES - 1) || fv < pitch_fixed(0)) begin
            dev        = -(longint'(1) << FRAC);
            r.in_range = 1'b0;
            r.index    = '0;
            r.dev      = dev[DEV_W-1:0];
            return r;
        end
        lo = 0;
        hi = NOTES - 1;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (fv < pitch_fixed(mid)) begin
                hi = mid;
            end else begin
                lo = mid;
            end
        end
        idx      = hi;
        has_up   = idx < NOTES - 1;
        has_down = idx > 0;
        a = fv - pitch_fixed(idx);
        b = has_up ? fv - pitch_fixed(idx + 1) : 0;
        c = has_down ? fv - pitch_fixed(idx - 1) : 0;
        // A missing neighbour never wins, and ties stay with the search result.
        if (has_up && magnitude(a) > magnitude(b)) begin
            if (has_down && b > c) begin
                pick = idx - 1;
                dev  = c;
            end else begin
                pick = idx + 1;
                dev  = b;
            end
        end else if (has_down && magnitude(a) > magnitude(c)) begin
            pick = idx - 1;
            dev  = c;
        end else begin
            pick = idx;
            dev  = a;
        end
        if (dev > DEV_MAX) begin
            dev = DEV_MAX;
        end
        if (dev < DEV_MIN) begin
            dev = DEV_MIN;
        end
        r.in_range = 1'b1;
        r.index    = pick[INDEX_W-1:0];
        r.dev      = dev[DEV_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup     want;
        t_note_match got;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                got.in_range = i_in_range;
                got.index    = i_note_index;
                got.dev      = i_deviation;
                if (lookup_q.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("%0t: result with no pending transaction: ", $realtime,
                                 "range %0b index %0d dev %0d",
                                 got.in_range, got.index, got.dev);
                    end
                    mismatches++;
                end else begin
                    want = lookup_q.pop_front();
                    if (want.match.in_range !== got.in_range
                        || want.match.index !== got.index
                        || want.match.dev !== got.dev) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("%0t: freq %0d: ", $realtime, want.freq,
                                     "expected range %0b index %0d dev %0d, ",
                                     want.match.in_range, want.match.index,
                                     want.match.dev,
                                     "got range %0b index %0d dev %0d",
                                     got.in_range, got.index, got.dev);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want.freq  = i_freq_in;
                want.match = nearest_note(i_freq_in);
                lookup_q.push_back(want);
            end
            pending_q <= lookup_q.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import nnl_pkg::*;

    localparam int ITEM_TOTAL   = 1850;
    localparam int IDLE_EVERY   = 400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int NOTES        = NOTE_COUNT_DEF;
    localparam int FREQ_TOP     = (1 << FREQ_W) - 1;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic [FREQ_W-1:0]       freq      = '0;
    logic                    out_ready = 1'b0;
    logic                    in_ready;
    logic                    out_valid;
    logic                    in_range;
    logic [INDEX_W-1:0]      note_index;
    logic signed [DEV_W-1:0] deviation;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    nearest_note_lookup u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_freq_in    (freq),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_in_range   (in_range),
        .o_note_index (note_index),
        .o_deviation  (deviation)
    );

    note_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_freq_in    (freq),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_in_range   (in_range),
        .i_note_index (note_index),
        .i_deviation  (deviation),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver switches between always ready, coin flips, rare acceptance and
    // long on/off blocks.
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 400);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                out_ready <= 1'b1;
            end
            1: begin
                out_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                out_ready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                out_ready <= stall_left[4];
            end
        endcase
    end

    function automatic int pitch_at(input int i);
        return int'(((longint'(NOTE_MILLI_HZ[i]) << FRAC_BITS_DEF) + 500) / 1000);
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        int sel, i, lo_v, hi_v;
        sel = $urandom_range(0, 99);
        i   = $urandom_range(0, NOTES - 1);
        if (sel < 12) begin
            // Midway between two neighbours, where the tie rule decides.
            if (i == NOTES - 1) begin
                i--;
            end
            return FREQ_W'((pitch_at(i) + pitch_at(i + 1) + $urandom_range(0, 1)) / 2);
        end else if (sel < 70) begin
            lo_v = (i > 0) ? (pitch_at(i - 1) + pitch_at(i)) / 2 - 3 : pitch_at(0) - 300;
            hi_v = (i < NOTES - 1) ? (pitch_at(i) + pitch_at(i + 1)) / 2 + 3
                                   : pitch_at(i) + 300;
            return FREQ_W'($urandom_range(lo_v, hi_v));
        end else if (sel < 85) begin
            return FREQ_W'($urandom_range(pitch_at(0), pitch_at(NOTES - 1)));
        end else if (sel < 90) begin
            return FREQ_W'($urandom_range(0, pitch_at(0) - 1));
        end else if (sel < 95) begin
            return FREQ_W'($urandom_range(pitch_at(NOTES - 1) + 1, FREQ_TOP));
        end
        return FREQ_W'($urandom_range(0, FREQ_TOP));
    endfunction

    task automatic send_freq(input logic [FREQ_W-1:0] f);
        int gap;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 24);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        freq     <= f;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        burst_left--;
    endtask

    // The checker's pending count is registered, so the task waits on the clock before it trusts that count.
    task automatic wait_all_returned();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        int directed_q[$];
        int top_pitch;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        top_pitch  = pitch_at(NOTES - 1);
        directed_q = '{0, 1, pitch_at(0) - 1, pitch_at(0), pitch_at(0) + 1, pitch_at(1),
                       4310, 4311, 4567, 5248, pitch_at(53), pitch_at(57),
                       pitch_at(NOTES - 2), (pitch_at(NOTES - 2) + top_pitch) / 2,
                       top_pitch - 1, top_pitch, top_pitch + 1, FREQ_TOP,
                       1 << (FREQ_W - 1), 21'h0AAAAA, 21'h155555};
        foreach (directed_q[k]) begin
            send_freq(FREQ_W'(directed_q[k]));
        end
        wait_all_returned();

        for (int n = 1; n <= ITEM_TOTAL; n++) begin
            send_freq(pick_freq());
            if (n % IDLE_EVERY == 0) begin
                wait_all_returned();
            end
        end
        wait_all_returned();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
